### src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned KeyW = 31;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 4;
  localparam int unsigned RecW = 25;

  // Divisors are one bit wider than a bucket index.
  localparam logic [IdxW:0] Dec100 = 11'd100;
  localparam logic [IdxW:0] Dec1000 = 11'd1000;

  // Reciprocals floor(2^31 / d); the estimated quotient is at most one short.
  localparam logic [RecW-1:0] Rec100 = 25'd21474836;
  localparam logic [RecW-1:0] Rec1000 = 25'd2147483;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] MODE_MOD = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_FOLD = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [2:0] REG_HASH_MODE = 3'd0;

  typedef struct packed {
    logic            req_type;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] bucket_index;
    logic [1:0]      status;
  } out_t;

  typedef struct packed {
    logic            op;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] bucket;
  } item_t;

endpackage

### src/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front
// Accepts requests and computes the bucket by reciprocal multiplication,
// one multiply, one subtract and one correction step per pass.
// ----------------------------------------------------------------------------
module cht_front #(
  parameter int unsigned NUM_BUCKETS = 100
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           enable_i,
  input  logic [1:0]     hash_mode_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cht_pkg::in_t   in_data_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output cht_pkg::item_t item_o
);

  localparam logic [cht_pkg::IdxW:0] NbM = (cht_pkg::IdxW + 1)'(NUM_BUCKETS);
  localparam logic [cht_pkg::RecW-1:0] RecNb =
    (cht_pkg::RecW)'((64'd1 << 31) / 64'(NUM_BUCKETS));

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_SUB  = 5'b00100,
    F_FIX  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e                  state_q, state_d;
  logic                     op_q, op_d;
  logic [cht_pkg::KeyW-1:0] key_q, key_d;
  logic                     fold_q, fold_d;
  logic [31:0]              v_q, v_d;
  logic [cht_pkg::IdxW:0]   div_q, div_d;
  logic [cht_pkg::RecW-1:0] rec_q, rec_d;
  logic [cht_pkg::RecW-1:0] qe_q, qe_d;
  logic [cht_pkg::IdxW:0]   re_q, re_d;
  logic [cht_pkg::IdxW-1:0] bkt_q, bkt_d;

  logic [31+cht_pkg::RecW:0] prod;
  logic [31:0]               qd, diff;
  logic [cht_pkg::IdxW:0]    r_fix;
  logic [cht_pkg::RecW-1:0]  q_fix;

  // The estimated quotient is exact or one short, so the remainder estimate
  // lies below twice the divisor and one compare and subtract finishes it.
  always_comb begin
    prod = (32 + cht_pkg::RecW)'(v_q) * (32 + cht_pkg::RecW)'(rec_q);
    qd = 32'(qe_q) * 32'(div_q);
    diff = v_q - qd;
    if (re_q >= div_q) begin
      r_fix = re_q - div_q;
      q_fix = qe_q + (cht_pkg::RecW)'(1);
    end else begin
      r_fix = re_q;
      q_fix = qe_q;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    key_d = key_q;
    fold_d = fold_q;
    v_d = v_q;
    div_d = div_q;
    rec_d = rec_q;
    qe_d = qe_q;
    re_d = re_q;
    bkt_d = bkt_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && enable_i) begin
          op_d = in_data_i.req_type;
          key_d = in_data_i.key;
          v_d = {1'b0, in_data_i.key};
          case (hash_mode_i)
            cht_pkg::MODE_DEC: begin
              div_d = cht_pkg::Dec100;
              rec_d = cht_pkg::Rec100;
              fold_d = 1'b0;
            end
            cht_pkg::MODE_FOLD: begin
              div_d = cht_pkg::Dec1000;
              rec_d = cht_pkg::Rec1000;
              fold_d = 1'b1;
            end
            default: begin
              div_d = NbM;
              rec_d = RecNb;
              fold_d = 1'b0;
            end
          endcase
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        qe_d = prod[31 +: cht_pkg::RecW];
        state_d = F_SUB;
      end
      F_SUB: begin
        re_d = diff[cht_pkg::IdxW:0];
        state_d = F_FIX;
      end
      F_FIX: begin
        if (fold_q) begin
          // Fold the quotient by 1000 onto the remainder, then reduce again.
          v_d = 32'(q_fix) + 32'(r_fix);
          div_d = NbM;
          rec_d = RecNb;
          fold_d = 1'b0;
          state_d = F_MUL;
        end else begin
          bkt_d = r_fix[cht_pkg::IdxW-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (item_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    key_q <= key_d;
    fold_q <= fold_d;
    v_q <= v_d;
    div_q <= div_d;
    rec_q <= rec_d;
    qe_q <= qe_d;
    re_q <= re_d;
    bkt_q <= bkt_d;
  end

  assign in_ready_o = (state_q == F_IDLE) && enable_i;
  assign item_valid_o = (state_q == F_PUSH);
  assign item_o = '{op: op_q, key: key_q, bucket: bkt_q};

endmodule

### src/cht_fifo.sv
// ----------------------------------------------------------------------------
// cht_fifo
// Two-entry queue of hashed requests between the front and back parts.
// ----------------------------------------------------------------------------
module cht_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  cht_pkg::item_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output cht_pkg::item_t rd_data_o
);

  cht_pkg::item_t ent_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;
  assign rd_data_o = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= wr_data_i;
    end
  end

endmodule

### src/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back
// Bucket row memory with read-modify-write execution of inserts and removes.
// ----------------------------------------------------------------------------
module cht_back #(
  parameter int unsigned NUM_BUCKETS = 100,
  parameter int unsigned SLOTS_PER_BUCKET = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  output logic           ready_o,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  cht_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cht_pkg::out_t  out_data_o
);

  localparam int unsigned AddrW = $clog2(NUM_BUCKETS);
  localparam int unsigned KW = cht_pkg::KeyW;
  localparam int unsigned CW = cht_pkg::CntW;
  localparam int unsigned RowW = SLOTS_PER_BUCKET * KW + CW;
  localparam logic [CW-1:0] Slots = CW'(SLOTS_PER_BUCKET);

  typedef enum logic [2:0] {
    B_CLR  = 3'b001,
    B_IDLE = 3'b010,
    B_EXEC = 3'b100
  } bstate_e;

  bstate_e        state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  cht_pkg::item_t item_q;
  logic           out_valid_q, out_valid_d;
  cht_pkg::out_t  out_q, out_d;

  logic [RowW-1:0] mem [NUM_BUCKETS];
  logic [RowW-1:0] row_q, wr_row;
  logic            rd_en, we;
  logic [AddrW-1:0] wa;

  logic [SLOTS_PER_BUCKET-1:0][KW-1:0] old_k, new_k;
  logic [CW-1:0]   cnt, pos, new_cnt;
  logic            found;
  logic [1:0]      status;

  // Row compute: slots in parallel, lowest match wins for a remove.
  always_comb begin
    cnt = row_q[CW-1:0];
    for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
      old_k[j] = row_q[CW + j*KW +: KW];
    end
    found = 1'b0;
    pos = '0;
    for (int j = SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
      if ((CW'(j) < cnt) && (old_k[j] == item_q.key)) begin
        found = 1'b1;
        pos = CW'(j);
      end
    end
    new_k = old_k;
    new_cnt = cnt;
    if (item_q.op == cht_pkg::OP_INSERT) begin
      if (cnt >= Slots) begin
        status = cht_pkg::ST_FULL;
      end else begin
        status = cht_pkg::ST_INSERTED;
        new_cnt = cnt + CW'(1);
        for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
          if (CW'(j) == cnt) begin
            new_k[j] = item_q.key;
          end
        end
      end
    end else begin
      if (found) begin
        status = cht_pkg::ST_REMOVED;
        new_cnt = cnt - CW'(1);
        for (int j = 0; j + 1 < SLOTS_PER_BUCKET; j++) begin
          if (CW'(j) >= pos) begin
            new_k[j] = old_k[j+1];
          end
        end
      end else begin
        status = cht_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    rd_en = 1'b0;
    we = 1'b0;
    wa = item_q.bucket[AddrW-1:0];
    wr_row = {new_k, new_cnt};
    case (state_q)
      B_CLR: begin
        we = 1'b1;
        wa = clr_q;
        wr_row = '0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NUM_BUCKETS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (item_valid_i) begin
          rd_en = 1'b1;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          we = 1'b1;
          out_valid_d = 1'b1;
          out_d = '{bucket_index: item_q.bucket, status: status};
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (rd_en) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wr_row;
    end
    if (rd_en) begin
      row_q <= mem[item_i.bucket[AddrW-1:0]];
    end
  end

  assign ready_o = (state_q != B_CLR);
  assign item_ready_o = (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

### src/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table of bounded buckets with insert and remove requests.
// ----------------------------------------------------------------------------
// After reset the engine clears the occupancy of every bucket, one bucket per
// cycle, and accepts no request until the clearing pass ends. In the front part
// a request is accepted, multiplied by a reciprocal, subtracted, corrected and
// handed over; folding mode reduces the folded sum in a second pass. The
// front hashes one key at a time, and this sets the rate. The back part reads
// the bucket row, updates it and writes it back, working on the previous
// request from a two-word queue meanwhile.
module chained_hash_table_engine #(
  parameter int unsigned NUM_BUCKETS = 100,
  parameter int unsigned SLOTS_PER_BUCKET = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cht_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cht_pkg::out_t out_data_o
);

  logic [1:0]     hash_mode_q;
  logic           back_ready;
  logic           f_valid, f_ready, b_valid, b_ready;
  cht_pkg::item_t f_item, b_item;

  assign pready = 1'b1;
  assign prdata = (paddr == cht_pkg::REG_HASH_MODE) ? {30'd0, hash_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_mode_q <= cht_pkg::MODE_MOD;
    end else if (psel && penable && pwrite && (paddr == cht_pkg::REG_HASH_MODE)) begin
      hash_mode_q <= pwdata[1:0];
    end
  end

  cht_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (back_ready),
    .hash_mode_i (hash_mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  cht_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_item),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_item)
  );

  cht_back #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (back_ready),
    .item_valid_i(b_valid),
    .item_ready_o(b_ready),
    .item_i      (b_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table engine.
// ----------------------------------------------------------------------------
module cht_checker #(
  parameter int unsigned NUM_BUCKETS = 100
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic [31:0]   prdata,
  input logic          pready,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cht_pkg::out_t out_data_o
);

  // A word offered on the result side holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Every reported bucket lies inside the table.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bucket_index < 10'(NUM_BUCKETS))
    else $error("bucket index out of range");

  // The bucket clearing pass keeps requests out right after reset.
  a_clr_block: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("engine active during clearing pass");

  // The mode register reads back within its two bits.
  a_prdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && prdata[31:2] == 30'd0)
    else $error("bad register read data");

endmodule

bind chained_hash_table_engine cht_checker #(.NUM_BUCKETS(NUM_BUCKETS)) u_cht_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Chained hash table engine testbench
// Drives insert and remove words into the engine under all hash modes and
// checks every result word against a bucket-level predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBuckets = 100;
  localparam int unsigned SlotsPerBucket = 8;
  localparam int unsigned KeyW = cht_pkg::KeyW;
  localparam int unsigned IdxW = cht_pkg::IdxW;
  localparam longint CycleLimit = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  cht_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  cht_pkg::out_t out_data_o;

  chained_hash_table_engine #(
    .NUM_BUCKETS(NumBuckets),
    .SLOTS_PER_BUCKET(SlotsPerBucket)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: bucket rows and the current hash mode.
  logic [KeyW-1:0] table_keys[NumBuckets][SlotsPerBucket];
  int unsigned     table_counts[NumBuckets];
  logic [1:0]      cur_mode;

  cht_pkg::out_t pending_results[$];
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  bit            hold_off;
  int unsigned   error_count;
  int unsigned   words_sent;
  int unsigned   words_checked;
  int unsigned   full_seen;
  int unsigned   notfound_seen;
  longint        cycle_count;

  function automatic int unsigned hash_bucket(logic [KeyW-1:0] key);
    int unsigned k;
    k = key;
    case (cur_mode)
      cht_pkg::MODE_DEC: return k % 100;
      cht_pkg::MODE_FOLD: return ((k / 1000) + (k % 1000)) % NumBuckets;
      default: return k % NumBuckets;
    endcase
  endfunction

  function automatic cht_pkg::out_t predict_request(cht_pkg::in_t req);
    cht_pkg::out_t res;
    int unsigned   b;
    int unsigned   cnt;
    int            hit;
    b = hash_bucket(req.key);
    cnt = table_counts[b];
    res.bucket_index = IdxW'(b);
    if (req.req_type == cht_pkg::OP_INSERT) begin
      if (cnt >= SlotsPerBucket) begin
        res.status = cht_pkg::ST_FULL;
      end else begin
        table_keys[b][cnt] = req.key;
        table_counts[b] = cnt + 1;
        res.status = cht_pkg::ST_INSERTED;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < cnt; i++) begin
        if (hit < 0 && table_keys[b][i] == req.key) hit = i;
      end
      if (hit < 0) begin
        res.status = cht_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < cnt; i++) table_keys[b][i] = table_keys[b][i + 1];
        table_counts[b] = cnt - 1;
        res.status = cht_pkg::ST_REMOVED;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (word %0d)", what, got, want,
             words_checked);
    error_count++;
  endtask

  // Inputs are driven with blocking assignments at the falling edge, so a drop
  // of valid and a new word in the same step never collide.
  task automatic send_request(logic op, logic [KeyW-1:0] key);
    cht_pkg::in_t req;
    req.req_type = op;
    req.key = key;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    pending_results.push_back(predict_request(req));
    in_data_i = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    // Leave some idle cycles before the mode register is touched.
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_hash_mode(logic [1:0] mode);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= cht_pkg::REG_HASH_MODE;
    pwdata <= 32'(mode);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_mode = mode;
  endtask

  // Result checker and receiver stall model.
  always @(posedge clk_i) begin
    cht_pkg::out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, bucket", out_data_o.bucket_index, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.bucket_index !== want.bucket_index)
          report_mismatch("bucket_index", out_data_o.bucket_index, want.bucket_index);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (want.status == cht_pkg::ST_FULL) full_seen++;
        if (want.status == cht_pkg::ST_NOT_FOUND) notfound_seen++;
        words_checked++;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] key_for_bucket(int unsigned b);
    // Multiples of 1000 plus b land in bucket b in every mode when b < 100
    // and the thousands part is a multiple of 100.
    return KeyW'(($urandom_range(20000) * 100 * 1000) % 32'h7FFF_0000 / 100000 * 100000 + b);
  endfunction

  task automatic test_directed();
    send_request(cht_pkg::OP_INSERT, '0);
    send_request(cht_pkg::OP_INSERT, '1);
    send_request(cht_pkg::OP_REMOVE, 31'd12345);
    send_request(cht_pkg::OP_REMOVE, '1);
    send_request(cht_pkg::OP_REMOVE, '1);
    // Fill bucket 7 past its capacity with duplicates and distinct keys.
    for (int i = 0; i < SlotsPerBucket + 2; i++)
      send_request(cht_pkg::OP_INSERT, (i % 2) ? 31'd7 : 31'(100 * i + 7));
    send_request(cht_pkg::OP_REMOVE, 31'd7);
    send_request(cht_pkg::OP_REMOVE, 31'd207);
    send_request(cht_pkg::OP_INSERT, 31'h5555_5555);
    send_request(cht_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_request(cht_pkg::OP_REMOVE, 31'h5555_5555);
    send_request(cht_pkg::OP_REMOVE, 31'h2AAA_AAAA);
  endtask

  task automatic test_random(int unsigned count);
    logic [KeyW-1:0] pool[$];
    logic [KeyW-1:0] k;
    int unsigned     sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 10) k = KeyW'($urandom());
      else if (sel < 40 && pool.size() != 0) k = pool[$urandom_range(pool.size() - 1)];
      else k = key_for_bucket($urandom_range(11));
      if (pool.size() < 64) pool.push_back(k);
      else pool[$urandom_range(63)] = k;
      send_request($urandom_range(99) < 55 ? cht_pkg::OP_INSERT : cht_pkg::OP_REMOVE, k);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      test_random(100);
    join
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 52;
    hold_off = 1'b0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    full_seen = 0;
    notfound_seen = 0;
    cycle_count = 0;
    cur_mode = cht_pkg::MODE_MOD;
    for (int b = 0; b < NumBuckets; b++) table_counts[b] = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    write_hash_mode(cht_pkg::MODE_DEC);
    test_directed();
    test_random(300);
    write_hash_mode(cht_pkg::MODE_FOLD);
    test_directed();
    test_random(300);
    test_backpressure();
    send_idle_pct = 52;
    recv_idle_pct = 11;
    write_hash_mode(cht_pkg::MODE_RSVD);
    test_random(300);
    write_hash_mode(cht_pkg::MODE_MOD);
    test_random(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_hash_mode(cht_pkg::MODE_FOLD);
    test_random(300);
    wait_drained();

    $display("Sent %0d request words, checked %0d results over four hash settings.",
             words_sent, words_checked);
    $display("Saw %0d bucket-full and %0d not-found results.", full_seen, notfound_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
